[design/ecs_pkg.sv]
// shared types and constants for the encoder count and speed block
// no dependencies; every other design file imports this package

package ecs_pkg;

  localparam int COUNT_BITS = 16;
  localparam int TIME_BITS  = 48;
  localparam int TOTAL_BITS = 48;
  localparam int SPEED_BITS = 32;

  // speed scale: thousandths of ticks per second from microsecond stamps
  localparam int unsigned SCALE_NUM  = 32'd1000 * 32'd1000000;
  localparam int          SCALE_BITS = 30;
  localparam logic [SCALE_BITS-1:0] SCALE = SCALE_BITS'(SCALE_NUM);

  // digit-serial multiplier: one 4-bit digit of the tick magnitude per cycle
  localparam int DIGIT_BITS = 4;
  localparam int MUL_DIGITS = TOTAL_BITS / DIGIT_BITS;
  localparam int ACC_BITS   = SCALE_BITS;
  localparam int SUM_BITS   = SCALE_BITS + DIGIT_BITS;
  localparam int PROD_BITS  = TOTAL_BITS + SCALE_BITS;

  // quotient keeps one bit above the speed width, plus a sticky overflow
  localparam int QUOT_BITS = SPEED_BITS + 1;
  localparam logic [QUOT_BITS-1:0] POS_MAX = QUOT_BITS'((64'd1 << (SPEED_BITS - 1)) - 64'd1);
  localparam logic [QUOT_BITS-1:0] NEG_MAG = QUOT_BITS'(64'd1 << (SPEED_BITS - 1));

  // action codes
  localparam logic [1:0] ACT_WRAP   = 2'd0;
  localparam logic [1:0] ACT_LATCH  = 2'd1;
  localparam logic [1:0] ACT_UPDATE = 2'd2;

  typedef struct packed {
    logic [1:0]         action;
    logic [47:0]        uptime;
    logic signed [15:0] raw_count;
    logic signed [15:0] wrap_value;
  } item_t;

  typedef struct packed {
    logic               status;
    logic signed [47:0] total_count;
    logic signed [31:0] speed;
    logic               speed_saturated;
  } result_t;

  typedef struct packed {
    logic                 big;
    logic [QUOT_BITS-1:0] quot;
  } div_res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUM,
    S_TOTAL,
    S_MUL,
    S_DIV,
    S_SAT,
    S_RESULT
  } state_t;

endpackage

[design/ecs_mul.sv]
// digit-serial multiplier: tick magnitude times the speed scale constant
// depends on ecs_pkg

module ecs_mul (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [ecs_pkg::TOTAL_BITS-1:0]   mcand,
  output logic                             done,
  output logic [ecs_pkg::PROD_BITS-1:0]    product
);
  import ecs_pkg::*;

  localparam int CNT_W = $clog2(MUL_DIGITS);

  logic                  busy;
  logic [CNT_W-1:0]      cnt;
  logic [TOTAL_BITS-1:0] mc;
  logic [ACC_BITS-1:0]   acc;
  logic [TOTAL_BITS-1:0] low;
  logic [SUM_BITS-1:0]   partial;
  logic [SUM_BITS-1:0]   sum;

  // one digit times the constant, added to the running upper part
  assign partial = SUM_BITS'(mc[DIGIT_BITS-1:0]) * SUM_BITS'(SCALE);
  assign sum     = SUM_BITS'(acc) + partial;
  assign product = {acc, low};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == CNT_W'(MUL_DIGITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mc  <= mcand;
      acc <= '0;
    end else if (busy) begin
      mc  <= mc >> DIGIT_BITS;
      acc <= sum[SUM_BITS-1:DIGIT_BITS];
      low <= {sum[DIGIT_BITS-1:0], low[TOTAL_BITS-1:DIGIT_BITS]};
    end
  end

endmodule

[design/ecs_div.sv]
// restoring divider, one quotient bit per cycle, with sticky overflow
// depends on ecs_pkg

module ecs_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [ecs_pkg::PROD_BITS-1:0]  numer,
  input  logic [ecs_pkg::TIME_BITS-1:0]  divisor,
  output logic                           done,
  output ecs_pkg::div_res_t              res
);
  import ecs_pkg::*;

  localparam int CNT_W = $clog2(PROD_BITS);

  logic                  busy;
  logic [CNT_W-1:0]      cnt;
  logic [PROD_BITS-1:0]  num;
  logic [TIME_BITS-1:0]  dvs;
  logic [TIME_BITS-1:0]  rem;
  logic [QUOT_BITS-1:0]  quot;
  logic                  big;
  logic [TIME_BITS:0]    trial;
  logic [TIME_BITS+1:0]  diff;
  logic                  fits;

  assign trial = {rem, num[PROD_BITS-1]};
  assign diff  = {1'b0, trial} - {2'b00, dvs};
  assign fits  = ~diff[TIME_BITS+1];

  assign res.big  = big;
  assign res.quot = quot;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == CNT_W'(PROD_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num  <= numer;
      dvs  <= divisor;
      rem  <= '0;
      quot <= '0;
      big  <= 1'b0;
    end else if (busy) begin
      num  <= num << 1;
      rem  <= fits ? diff[TIME_BITS-1:0] : trial[TIME_BITS-1:0];
      quot <= {quot[QUOT_BITS-2:0], fits};
      // a bit leaving the top means the quotient is far beyond range
      big  <= big | quot[QUOT_BITS-1];
    end
  end

endmodule

[design/encoder_count_and_speed_top.sv]
// encoder count and speed: top level with control sequencer and state
// depends on ecs_pkg, ecs_mul, ecs_div
//
// usage:
//   item channel (item_valid / item_stall / item) carries one action per
//   transaction: wrap adds wrap_value to the pending correction, latch
//   records uptime and raw_count, update folds the raw delta and the
//   correction into the total and, for a nonzero time interval, recomputes speed.
//   result channel (result_valid / result_stall / result) returns exactly one
//   transaction per item: status, total count, last valid speed and its
//   saturation flag.
//   wrap, latch and unused codes go from acceptance straight to the result
//   state; an update with a zero time interval passes the sum and total
//   states first; an update that computes speed also runs the digit-serial
//   multiply (4 bits per step) and the restoring divide (one quotient bit
//   per step), then the saturation step, before the result state.
//   one item is in flight at a time; item_stall stays high until its result
//   sits in the output register, then the next item is taken while that
//   result waits.
//   reset (rst, synchronous) clears all counts, latches and speed to zero.
//   while result_stall is high the result holds and the block waits with the
//   next result until the output register frees up.

module encoder_count_and_speed_top (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  ecs_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output ecs_pkg::result_t result
);
  import ecs_pkg::*;

  state_t state, state_next;

  // architectural state
  logic [TIME_BITS-1:0]  latch_now, latch_before;
  logic [COUNT_BITS-1:0] raw_now, raw_before;
  logic [TOTAL_BITS-1:0] pending_wrap, total_ticks;
  logic [SPEED_BITS-1:0] speed_value;
  logic                  speed_clamped;

  // per-update working registers
  logic [COUNT_BITS:0]   delta_raw;
  logic [TIME_BITS:0]    tdiff;
  logic                  tzero;
  logic [TOTAL_BITS-1:0] tick_delta;
  logic [TIME_BITS-1:0]  dmag;
  logic                  dneg;
  logic                  tneg;
  logic                  status_flag;

  // sequencer outputs
  logic mul_start, div_start, result_load;

  // datapath between the serial units
  logic [TOTAL_BITS-1:0] tmag;
  logic                  mul_done, div_done;
  logic [PROD_BITS-1:0]  product;
  div_res_t              div_res;

  // speed clamping
  logic                  q_nonzero, speed_neg, pos_clamp, neg_clamp;
  logic [QUOT_BITS-1:0]  neg_mag;

  // magnitude of the tick delta; the most negative value maps to 2^(w-1)
  assign tmag = tick_delta[TOTAL_BITS-1] ? (~tick_delta + 1'b1) : tick_delta;

  ecs_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .mcand   (tmag),
    .done    (mul_done),
    .product (product)
  );

  ecs_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .numer   (product),
    .divisor (dmag),
    .done    (div_done),
    .res     (div_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    mul_start   = 1'b0;
    div_start   = 1'b0;
    result_load = 1'b0;
    item_stall  = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          state_next = (item.action == ACT_UPDATE) ? S_SUM : S_RESULT;
        end
      end
      S_SUM: begin
        state_next = S_TOTAL;
      end
      S_TOTAL: begin
        // zero interval: keep the old speed and report it
        if (tzero) begin
          state_next = S_RESULT;
        end else begin
          mul_start  = 1'b1;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        if (mul_done) begin
          div_start  = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_next = S_SAT;
        end
      end
      S_SAT: begin
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (!result_valid || !result_stall) begin
          result_load = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // sign of the speed and clamp decisions from the finished quotient
  assign q_nonzero = div_res.big || (div_res.quot != '0);
  assign speed_neg = (tneg ^ dneg) && q_nonzero;
  assign pos_clamp = div_res.big || (div_res.quot > POS_MAX);
  assign neg_clamp = div_res.big || (div_res.quot > NEG_MAG);
  assign neg_mag   = neg_clamp ? NEG_MAG : div_res.quot;

  always_ff @(posedge clk) begin
    if (rst) begin
      latch_now     <= '0;
      latch_before  <= '0;
      raw_now       <= '0;
      raw_before    <= '0;
      pending_wrap  <= '0;
      total_ticks   <= '0;
      speed_value   <= '0;
      speed_clamped <= 1'b0;
      status_flag   <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (item_valid) begin
            status_flag <= 1'b0;
            case (item.action)
              ACT_WRAP: begin
                pending_wrap <= pending_wrap
                              + {{(TOTAL_BITS-16){item.wrap_value[15]}}, item.wrap_value};
              end
              ACT_LATCH: begin
                latch_before <= latch_now;
                latch_now    <= item.uptime;
                raw_before   <= raw_now;
                raw_now      <= item.raw_count;
              end
              default: begin
              end
            endcase
          end
        end
        S_TOTAL: begin
          total_ticks  <= total_ticks + tick_delta;
          pending_wrap <= '0;
          status_flag  <= tzero;
        end
        S_SAT: begin
          if (!speed_neg) begin
            speed_clamped <= pos_clamp;
            speed_value   <= pos_clamp ? POS_MAX[SPEED_BITS-1:0]
                                       : div_res.quot[SPEED_BITS-1:0];
          end else begin
            speed_clamped <= neg_clamp;
            speed_value   <= ~neg_mag[SPEED_BITS-1:0] + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // working registers for an update, no reset needed
  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      delta_raw <= {raw_now[COUNT_BITS-1], raw_now} - {raw_before[COUNT_BITS-1], raw_before};
      tdiff     <= {1'b0, latch_now} - {1'b0, latch_before};
      tzero     <= (latch_now == latch_before);
    end
    if (state == S_SUM) begin
      tick_delta <= {{(TOTAL_BITS-COUNT_BITS-1){delta_raw[COUNT_BITS]}}, delta_raw}
                  + pending_wrap;
      dneg       <= tdiff[TIME_BITS];
      dmag       <= tdiff[TIME_BITS] ? (~tdiff[TIME_BITS-1:0] + 1'b1)
                                     : tdiff[TIME_BITS-1:0];
    end
    if (state == S_TOTAL) begin
      tneg <= tick_delta[TOTAL_BITS-1];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (result_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_load) begin
      result.status          <= status_flag;
      result.total_count     <= total_ticks;
      result.speed           <= speed_value;
      result.speed_saturated <= speed_clamped;
    end
  end

endmodule

[design/ecs_checker.sv]
// port-level checks for the encoder count and speed block, bound to the top
// depends on ecs_pkg and encoder_count_and_speed_top

module ecs_checker (
  input logic             clk,
  input logic             rst,
  input logic             item_valid,
  input logic             item_stall,
  input ecs_pkg::item_t   item,
  input logic             result_valid,
  input logic             result_stall,
  input ecs_pkg::result_t result
);
  import ecs_pkg::*;

  // a stalled result transaction holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // a stalled item transaction holds
  a_item_hold: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_stall |=> item_valid && $stable(item))
    else $error("item changed while stalled");

  // one item in flight: an accepted item closes the input at once
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("item accepted while another is in flight");

  // a saturated speed sits at one of the two limits
  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.speed_saturated |->
      result.speed == 32'sh7FFFFFFF || result.speed == 32'sh80000000)
    else $error("saturated speed not at a limit");

  // nothing is offered right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

endmodule

bind encoder_count_and_speed_top ecs_checker u_ecs_checker (.*);

[verif/encoder_count_and_speed_top_tb.sv]
// self-checking testbench for encoder_count_and_speed_top: a directed table, then random
// wrap / latch / update sequences, checked against hand-written readings or an in-bench position and speed model
// depends on ecs_pkg and the design files only

module encoder_count_and_speed_top_tb;

  import ecs_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int RANDOM_ITEMS = 1200;
  localparam int DRAIN_CYCLES = 200;

  localparam logic [1:0] ACT_SPARE          = 2'd3;  // unused action code
  localparam logic       STATUS_OK          = 1'b0;
  localparam logic       STATUS_NO_INTERVAL = 1'b1;

  localparam logic [95:0] TICK_SCALE = 96'd1_000_000_000;  // thousandths per second from us
  localparam logic [95:0] POS_LIMIT  = 96'h7FFF_FFFF;
  localparam logic [95:0] NEG_LIMIT  = 96'h8000_0000;

  typedef struct packed {
    item_t   it;
    logic    typed;   // want holds a hand-written reading
    result_t want;
  } stim_row_t;

  logic    clk          = 1'b0;
  logic    rst          = 1'b1;
  logic    item_valid   = 1'b0;
  logic    item_stall;
  item_t   item         = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;

  encoder_count_and_speed_top dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always begin
    #(CLK_PERIOD / 2) clk = 1'b1;
    #(CLK_PERIOD / 2) clk = 1'b0;
  end

  // model of the counter extension and speed meter
  logic [TIME_BITS-1:0]  stamp_now   = '0;
  logic [TIME_BITS-1:0]  stamp_prev  = '0;
  logic [COUNT_BITS-1:0] raw_latched = '0;
  logic [COUNT_BITS-1:0] raw_prev    = '0;
  logic [TOTAL_BITS-1:0] wrap_sum    = '0;
  logic [TOTAL_BITS-1:0] position    = '0;
  logic [31:0]           speed_now   = '0;
  logic                  speed_sat   = 1'b0;

  result_t expected_readings[$];
  stim_row_t directed_rows[$];

  int errors        = 0;
  int send_idle_pct = 32;
  int stall_pct     = 83;

  // shaping state for the random latch items
  logic [TIME_BITS-1:0]  clock_us    = '0;
  logic [COUNT_BITS-1:0] count_track = '0;

  function automatic result_t next_reading(input item_t it);
    logic [TOTAL_BITS-1:0] tick_step;
    logic [TOTAL_BITS-1:0] tick_mag;
    logic [TOTAL_BITS-1:0] span_mag;
    logic                  tick_neg;
    logic                  span_neg;
    logic [95:0]           quot;
    result_t               r;
    r.status = STATUS_OK;
    case (it.action)
      ACT_WRAP: begin
        wrap_sum = wrap_sum + {{(TOTAL_BITS-16){it.wrap_value[15]}}, it.wrap_value};
      end
      ACT_LATCH: begin
        stamp_prev  = stamp_now;
        stamp_now   = it.uptime;
        raw_prev    = raw_latched;
        raw_latched = it.raw_count;
      end
      ACT_UPDATE: begin
        tick_step = {{(TOTAL_BITS-COUNT_BITS){raw_latched[COUNT_BITS-1]}}, raw_latched}
                  - {{(TOTAL_BITS-COUNT_BITS){raw_prev[COUNT_BITS-1]}}, raw_prev}
                  + wrap_sum;
        position = position + tick_step;
        wrap_sum = '0;
        if (stamp_now == stamp_prev) begin
          r.status = STATUS_NO_INTERVAL;   // speed and its flag hold
        end else begin
          tick_neg = tick_step[TOTAL_BITS-1];
          tick_mag = tick_neg ? -tick_step : tick_step;
          span_neg = stamp_now < stamp_prev;
          span_mag = span_neg ? stamp_prev - stamp_now : stamp_now - stamp_prev;
          quot = ({48'd0, tick_mag} * TICK_SCALE) / {48'd0, span_mag};
          if ((tick_neg != span_neg) && (quot != 0)) begin
            speed_sat = quot > NEG_LIMIT;
            speed_now = speed_sat ? 32'h8000_0000 : -quot[31:0];
          end else begin
            speed_sat = quot > POS_LIMIT;
            speed_now = speed_sat ? 32'h7FFF_FFFF : quot[31:0];
          end
        end
      end
      default: begin
      end
    endcase
    r.total_count     = position;
    r.speed           = speed_now;
    r.speed_saturated = speed_sat;
    return r;
  endfunction

  function automatic result_t reading(input logic st, input logic [47:0] total,
                                      input logic [31:0] spd, input logic sat);
    result_t r;
    r.status          = st;
    r.total_count     = total;
    r.speed           = spd;
    r.speed_saturated = sat;
    return r;
  endfunction

  function automatic stim_row_t row(input logic [1:0] act, input logic [47:0] up,
                                    input logic [15:0] raw, input logic [15:0] wrap,
                                    input logic typed, input result_t want);
    stim_row_t s;
    s.it.action     = act;
    s.it.uptime     = up;
    s.it.raw_count  = raw;
    s.it.wrap_value = wrap;
    s.typed         = typed;
    s.want          = want;
    return s;
  endfunction

  // random content; wraps lean on the counter limits, latches follow a moving clock
  function automatic item_t shaped_item(input logic [1:0] act);
    item_t       it;
    logic [63:0] noise;
    noise         = {$urandom, $urandom};
    it.action     = act;
    it.uptime     = noise[47:0];
    it.raw_count  = 16'($urandom);
    it.wrap_value = 16'($urandom);
    if (act == ACT_WRAP && $urandom_range(1) == 1) begin
      it.wrap_value = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
    end
    if (act == ACT_LATCH) begin
      case ($urandom_range(4))
        0:       it.uptime = clock_us + 48'($urandom_range(4));       // tiny or zero interval
        1, 2:    it.uptime = clock_us + 48'($urandom_range(100_000));
        3:       it.uptime = clock_us - 48'($urandom_range(1000));    // clock going backwards
        default: begin
        end
      endcase
      if ($urandom_range(1) == 1) begin
        it.raw_count = count_track + 16'($urandom_range(4000)) - 16'd2000;
      end
      clock_us    = it.uptime;
      count_track = it.raw_count;
    end
    return it;
  endfunction

  // present one transaction, hold it until taken, then log what it should produce
  task automatic send_item(input item_t it, input logic typed, input result_t want);
    result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    predicted = next_reading(it);
    expected_readings.push_back(typed ? want : predicted);
  endtask

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  // result side: check every taken transaction, stall at random
  always @(posedge clk) begin : result_monitor
    result_t want;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_readings.size() == 0) begin
          errors++;
          $display("%0t: result with nothing outstanding, expected none, actual %h",
                   $time, result);
        end else begin
          want = expected_readings.pop_front();
          compare_field("status", want.status, result.status);
          compare_field("total_count", want.total_count, result.total_count);
          compare_field("speed", want.speed, result.speed);
          compare_field("speed_saturated", want.speed_saturated, result.speed_saturated);
        end
      end
      result_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  initial begin : stimulus
    int sent;
    int wraps;
    // right after reset: everything reads zero, latches equal so no interval
    directed_rows.push_back(row(ACT_WRAP, 48'd0, 16'd0, 16'd0, 1'b1,
                                reading(STATUS_OK, 48'd0, 32'd0, 1'b0)));
    directed_rows.push_back(row(ACT_UPDATE, 48'd0, 16'd0, 16'd0, 1'b1,
                                reading(STATUS_NO_INTERVAL, 48'd0, 32'd0, 1'b0)));
    directed_rows.push_back(row(ACT_SPARE, 48'hFFFF_FFFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b1,
                                reading(STATUS_OK, 48'd0, 32'd0, 1'b0)));
    // both wrap limits, then a zero interval still folds the ticks into the total
    directed_rows.push_back(row(ACT_WRAP, 48'd0, 16'd0, 16'h7FFF, 1'b0, '0));
    directed_rows.push_back(row(ACT_WRAP, 48'd0, 16'd0, 16'h8000, 1'b0, '0));
    directed_rows.push_back(row(ACT_LATCH, 48'd0, 16'h7FFF, 16'd0, 1'b0, '0));
    directed_rows.push_back(row(ACT_UPDATE, 48'd0, 16'd0, 16'd0, 1'b1,
                                reading(STATUS_NO_INTERVAL, 48'd32766, 32'd0, 1'b0)));
    // full negative swing over one microsecond clamps to the negative limit
    directed_rows.push_back(row(ACT_LATCH, 48'd1, 16'h8000, 16'd0, 1'b0, '0));
    directed_rows.push_back(row(ACT_UPDATE, 48'd0, 16'd0, 16'd0, 1'b1,
                                reading(STATUS_OK, -48'sd32769, 32'h8000_0000, 1'b1)));
    // widest forward interval, then widest backward one
    directed_rows.push_back(row(ACT_LATCH, 48'hFFFF_FFFF_FFFF, 16'h7FFF, 16'd0, 1'b0, '0));
    directed_rows.push_back(row(ACT_UPDATE, 48'd0, 16'd0, 16'd0, 1'b0, '0));
    directed_rows.push_back(row(ACT_LATCH, 48'd0, 16'd0, 16'd0, 1'b0, '0));
    directed_rows.push_back(row(ACT_UPDATE, 48'd0, 16'd0, 16'd0, 1'b0, '0));
    // full positive swing over one microsecond clamps to the positive limit
    directed_rows.push_back(row(ACT_LATCH, 48'd5, 16'h8000, 16'd0, 1'b0, '0));
    directed_rows.push_back(row(ACT_LATCH, 48'd6, 16'h7FFF, 16'd0, 1'b0, '0));
    directed_rows.push_back(row(ACT_UPDATE, 48'd0, 16'd0, 16'd0, 1'b0, '0));
    // no ticks over a real interval gives zero speed, flag cleared
    directed_rows.push_back(row(ACT_LATCH, 48'd100, 16'd0, 16'd0, 1'b0, '0));
    directed_rows.push_back(row(ACT_LATCH, 48'd200, 16'd0, 16'd0, 1'b0, '0));
    directed_rows.push_back(row(ACT_UPDATE, 48'd0, 16'd0, 16'd0, 1'b0, '0));
    // negative ticks with time going backwards reads as a positive speed
    directed_rows.push_back(row(ACT_LATCH, 48'd150, 16'd0, 16'd0, 1'b0, '0));
    directed_rows.push_back(row(ACT_WRAP, 48'd0, 16'd0, 16'hFFFF, 1'b0, '0));
    directed_rows.push_back(row(ACT_UPDATE, 48'd0, 16'd0, 16'd0, 1'b0, '0));
    // repeated stamp: status flags it, old speed stays
    directed_rows.push_back(row(ACT_WRAP, 48'd0, 16'd0, 16'd1, 1'b0, '0));
    directed_rows.push_back(row(ACT_LATCH, 48'd150, 16'd10, 16'd0, 1'b0, '0));
    directed_rows.push_back(row(ACT_UPDATE, 48'd0, 16'd0, 16'd0, 1'b0, '0));
    directed_rows.push_back(row(ACT_SPARE, 48'd0, 16'd0, 16'd0, 1'b0, '0));

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].it, directed_rows[i].typed, directed_rows[i].want);
    end

    // random part: mostly wrap* latch update runs, the rest arbitrary transactions
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent >= 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 0;
        stall_pct     = 0;
      end else if (sent >= RANDOM_ITEMS / 3) begin
        send_idle_pct = 83;
        stall_pct     = 32;
      end
      if ($urandom_range(99) < 75) begin
        wraps = $urandom_range(3);
        repeat (wraps) send_item(shaped_item(ACT_WRAP), 1'b0, '0);
        send_item(shaped_item(ACT_LATCH), 1'b0, '0);
        send_item(shaped_item(ACT_UPDATE), 1'b0, '0);
        sent += wraps + 2;
      end else begin
        send_item(shaped_item(2'($urandom_range(3))), 1'b0, '0);
        sent++;
      end
    end
    item_valid <= 1'b0;

    // drain, then give a late or extra result time to show up
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin : watchdog
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("%0t: timeout, %0d results still outstanding", $time, expected_readings.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
